[rtl/mwa_pkg.sv]
// Shared types and constants for the multichannel window averager.
package mwa_pkg;

    localparam int MAX_CHANNELS_DEF = 16;

    localparam int SAMPLE_W   = 12;
    localparam int CH_W       = 4;
    localparam int CC_W       = 5;
    localparam int WS_W       = 20;
    localparam int SUM_W      = 32;
    // effective channel count width, covers MAX_CHANNELS up to 32
    localparam int CNT_W      = 6;
    localparam int CFG_ADDR_W = 1;
    localparam int TDATA_W    = 16;

    localparam logic [CC_W-1:0]     CC_RESET = 5'd1;
    localparam logic [WS_W-1:0]     WS_RESET = 20'd1000;
    localparam logic [SAMPLE_W-1:0] AVG_MAX  = 12'hFFF;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_CHANNELS   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SAMPLES = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CHAN,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/mwa_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
module mwa_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mwa_pkg::SUM_W-1:0]  dividend,
    input  logic [mwa_pkg::WS_W-1:0]   divisor,
    output mwa_pkg::div_stat_t         stat,
    output logic [mwa_pkg::SUM_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(mwa_pkg::SUM_W);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [STEP_W-1:0]         cnt_reg, cnt_next;
    logic [mwa_pkg::SUM_W-1:0] q_reg, q_next;
    logic [mwa_pkg::WS_W-1:0]  rem_reg, rem_next;
    logic [mwa_pkg::WS_W-1:0]  d_reg, d_next;

    logic [mwa_pkg::WS_W:0]    trial;
    logic [mwa_pkg::WS_W:0]    diff;
    logic                      borrow;

    assign trial  = {rem_reg, q_reg[mwa_pkg::SUM_W-1]};
    assign diff   = trial - {1'b0, d_reg};
    assign borrow = diff[mwa_pkg::WS_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[mwa_pkg::SUM_W-2:0], ~borrow};
            rem_next = borrow ? trial[mwa_pkg::WS_W-1:0] : diff[mwa_pkg::WS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(mwa_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

[rtl/multichannel_window_averager_unit.sv]
// Top level of the multichannel window averager.
//
// Input stream s_axis: one 12-bit conversion result per request, channels
// interleaved round-robin from channel 0. Each request is added to its
// channel's 32-bit running sum in the cycle it is taken.
// Output stream m_axis: at window end one request per channel, in channel
// order, carrying the channel number and its average; tlast marks the
// final channel of the window.
// Config port: cfg_we/cfg_addr/cfg_wdata, index 0 channel count,
// index 1 window length. Write only while the block is idle.
// Throughput: samples that do not close a window stream at one per cycle
// while the block is idle. A sample that closes a window starts a 32-step
// serial divider, which first forms the per-channel divisor and then each
// channel average in turn. The first average shows once both divisions are
// done, and each later one once its own division, started when the one
// before it is taken, is done. The input is not ready until the last average
// is taken. A stalled receiver holds the current average and the sequencer.
// Reset: channel count 1, window length 1000, sums, count and position 0.
module multichannel_window_averager_unit #(
    parameter int MAX_CHANNELS = mwa_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mwa_pkg::TDATA_W-1:0]     s_axis_tdata,   // [11:0] sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mwa_pkg::TDATA_W-1:0]     m_axis_tdata,   // [3:0] channel, [15:4] average
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [mwa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mwa_pkg::WS_W-1:0]        cfg_wdata
);

    localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    mwa_pkg::state_t state_reg, state_next;

    logic [mwa_pkg::CC_W-1:0]     cc_reg;
    logic [mwa_pkg::WS_W-1:0]     ws_reg;
    logic [PW-1:0]                pos_reg, pos_next;
    logic [mwa_pkg::WS_W-1:0]     count_reg, count_next;
    logic [PW-1:0]                ch_reg, ch_next;
    logic [mwa_pkg::WS_W-1:0]     divisor_reg;
    logic [mwa_pkg::SAMPLE_W-1:0] avg_reg;
    logic [mwa_pkg::SUM_W-1:0]    sums_reg [MAX_CHANNELS];
    logic [mwa_pkg::SUM_W-1:0]    sum_next;

    logic [mwa_pkg::CNT_W-1:0]    cc_ext;
    logic [mwa_pkg::CNT_W-1:0]    n_eff;
    logic [PW-1:0]                pos_use;
    logic [mwa_pkg::CNT_W-1:0]    pos_inc;
    logic [mwa_pkg::WS_W-1:0]     count_inc;
    logic                         win_end;
    logic [PW-1:0]                ch_sel;
    logic [PW-1:0]                rd_addr;
    logic [mwa_pkg::SUM_W-1:0]    rd_sum;
    logic                         is_last;

    logic                         in_acc;
    logic                         out_acc;
    logic                         div_start;
    logic                         clear_win;
    logic [mwa_pkg::SUM_W-1:0]    div_dividend;
    logic [mwa_pkg::WS_W-1:0]     div_divisor;
    mwa_pkg::div_stat_t           div_stat;
    logic [mwa_pkg::SUM_W-1:0]    div_quot;
    logic [mwa_pkg::SAMPLE_W-1:0] avg_sat;

    // effective channel count: zero acts as one, clamp to MAX_CHANNELS
    assign cc_ext = mwa_pkg::CNT_W'(cc_reg);
    always_comb
    begin
        n_eff = cc_ext;
        if (cc_ext == '0)
            n_eff = mwa_pkg::CNT_W'(1);
        else if (cc_ext > mwa_pkg::CNT_W'(MAX_CHANNELS))
            n_eff = mwa_pkg::CNT_W'(MAX_CHANNELS);
    end

    assign pos_use   = (mwa_pkg::CNT_W'(pos_reg) >= n_eff) ? '0 : pos_reg;
    assign pos_inc   = mwa_pkg::CNT_W'(pos_use) + 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign win_end   = count_inc >= ws_reg;

    assign ch_sel  = (state_reg == mwa_pkg::ST_SEND) ? ch_reg + 1'b1 : '0;
    assign rd_addr = (state_reg == mwa_pkg::ST_IDLE) ? pos_use : ch_sel;
    assign rd_sum  = sums_reg[rd_addr];
    assign is_last = (mwa_pkg::CNT_W'(ch_reg) + 1'b1) == n_eff;

    assign sum_next = rd_sum + mwa_pkg::SUM_W'(s_axis_tdata[mwa_pkg::SAMPLE_W-1:0]);

    assign avg_sat = (|div_quot[mwa_pkg::SUM_W-1:mwa_pkg::SAMPLE_W])
                     ? mwa_pkg::AVG_MAX : div_quot[mwa_pkg::SAMPLE_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwa_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && win_end)
                    state_next = mwa_pkg::ST_SCALE;
            end
            mwa_pkg::ST_SCALE:
            begin
                if (div_stat.done)
                    state_next = mwa_pkg::ST_CHAN;
            end
            mwa_pkg::ST_CHAN:
            begin
                if (div_stat.done)
                    state_next = mwa_pkg::ST_SEND;
            end
            mwa_pkg::ST_SEND:
            begin
                if (m_axis_tready)
                    state_next = is_last ? mwa_pkg::ST_IDLE : mwa_pkg::ST_CHAN;
            end
            default:
                state_next = mwa_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        in_acc        = 1'b0;
        out_acc       = 1'b0;
        div_start     = 1'b0;
        clear_win     = 1'b0;
        div_dividend  = rd_sum;
        div_divisor   = divisor_reg;
        case (state_reg)
            mwa_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                in_acc        = s_axis_tvalid;
                div_start     = s_axis_tvalid && win_end;
                div_dividend  = mwa_pkg::SUM_W'(ws_reg);
                div_divisor   = mwa_pkg::WS_W'(n_eff);
            end
            mwa_pkg::ST_SCALE:
            begin
                div_start   = div_stat.done;
                div_divisor = div_quot[mwa_pkg::WS_W-1:0];
            end
            mwa_pkg::ST_CHAN:
            begin
            end
            mwa_pkg::ST_SEND:
            begin
                m_axis_tvalid = 1'b1;
                out_acc       = m_axis_tready;
                div_start     = m_axis_tready && !is_last;
                clear_win     = m_axis_tready && is_last;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        ch_next    = ch_reg;
        if (in_acc)
        begin
            pos_next   = (pos_inc >= n_eff) ? '0 : PW'(pos_inc);
            count_next = count_inc;
        end
        if (state_reg == mwa_pkg::ST_SCALE && div_stat.done)
            ch_next = '0;
        if (out_acc && !is_last)
            ch_next = ch_reg + 1'b1;
        if (clear_win)
        begin
            pos_next   = '0;
            count_next = '0;
        end
    end

    mwa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwa_pkg::ST_IDLE;
            cc_reg    <= mwa_pkg::CC_RESET;
            ws_reg    <= mwa_pkg::WS_RESET;
            pos_reg   <= '0;
            count_reg <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            ch_reg    <= ch_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    mwa_pkg::REG_NUM_CHANNELS:   cc_reg <= cfg_wdata[mwa_pkg::CC_W-1:0];
                    mwa_pkg::REG_WINDOW_SAMPLES: ws_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
                sums_reg[i] <= '0;
        end
        else if (clear_win)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
                sums_reg[i] <= '0;
        end
        else if (in_acc)
        begin
            sums_reg[pos_use] <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mwa_pkg::ST_SCALE && div_stat.done)
            divisor_reg <= div_quot[mwa_pkg::WS_W-1:0];
        if (state_reg == mwa_pkg::ST_CHAN && div_stat.done)
            avg_reg <= avg_sat;
    end

    assign m_axis_tdata = {avg_reg, mwa_pkg::CH_W'(ch_reg)};
    assign m_axis_tlast = is_last;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after final average");

    a_next_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !m_axis_tvalid)
        else $error("next average shown without a division");

    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |=> !div_stat.done)
        else $error("divider done held");

endmodule

[bench/multichannel_window_averager_unit_tb.sv]
// Testbench for multichannel_window_averager_unit: directed and random sample streams.
`timescale 1ns / 1ps

module multichannel_window_averager_unit_tb;
    import mwa_pkg::*;

    localparam int MAX_CH          = MAX_CHANNELS_DEF;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int IDLE_GAP        = 8;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] average;
        logic                last;
    } avg_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [WS_W-1:0]       cfg_wdata = '0;

    // predictor state
    logic [CC_W-1:0]  model_channels = CC_RESET;
    logic [WS_W-1:0]  model_window = WS_RESET;
    logic [SUM_W-1:0] chan_sum [MAX_CH] = '{default: '0};
    logic [WS_W-1:0]  samples_seen = '0;
    int unsigned      next_chan = 0;
    avg_result_t      avg_queue [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 17;
    int  recv_stall_pct = 56;
    bit  hold_off_request = 1'b0;
    int  hold_left = 0;

    multichannel_window_averager_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int unsigned active_channels();
        int unsigned n;
        n = model_channels;
        if (n == 0)
            n = 1;
        if (n > MAX_CH)
            n = MAX_CH;
        return n;
    endfunction

    function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] value);
        int unsigned n;
        logic [WS_W-1:0]  divisor;
        logic [SUM_W-1:0] quotient;
        avg_result_t      r;
        n = active_channels();
        if (next_chan >= n)
            next_chan = 0;
        chan_sum[next_chan] += SUM_W'(value);
        next_chan++;
        if (next_chan >= n)
            next_chan = 0;
        samples_seen++;
        if (samples_seen < model_window)
            return;
        divisor = model_window / WS_W'(n);
        for (int i = 0; i < n; i++)
        begin
            if (divisor == 0)
                quotient = SUM_W'(AVG_MAX);
            else
                quotient = chan_sum[i] / SUM_W'(divisor);
            r.channel = CH_W'(i);
            r.average = (quotient > SUM_W'(AVG_MAX)) ? AVG_MAX : quotient[SAMPLE_W-1:0];
            r.last = (i + 1 == n);
            avg_queue.push_back(r);
        end
        chan_sum = '{default: '0};
        samples_seen = '0;
        next_chan = 0;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off_request)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        avg_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (avg_queue.size() == 0)
            begin
                $error("unexpected average request: channel %0d, average %0d",
                       m_axis_tdata[CH_W-1:0], m_axis_tdata[CH_W +: SAMPLE_W]);
                error_count++;
            end
            else
            begin
                want = avg_queue.pop_front();
                if (m_axis_tdata[CH_W-1:0] !== want.channel)
                begin
                    $error("channel mismatch: expected %0d, got %0d",
                           want.channel, m_axis_tdata[CH_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[CH_W +: SAMPLE_W] !== want.average)
                begin
                    $error("average mismatch: expected %0d, got %0d",
                           want.average, m_axis_tdata[CH_W +: SAMPLE_W]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last mismatch: expected %0d, got %0d", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(TDATA_W-SAMPLE_W){1'b0}}, value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        accumulate_sample(value);
    endtask

    task automatic drain_averages();
        s_axis_tvalid <= 1'b0;
        while (avg_queue.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_config_reg(input logic [CFG_ADDR_W-1:0] index,
                                    input logic [WS_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == REG_NUM_CHANNELS)
            model_channels = value[CC_W-1:0];
        else
            model_window = value;
    endtask

    // channel count still at its reset value
    task automatic test_default_channels();
        write_config_reg(REG_WINDOW_SAMPLES, 20'd3);
        send_sample(12'hFFF);
        send_sample(12'hFFF);
        send_sample(12'h000);
        drain_averages();
    endtask

    task automatic test_saturation();
        write_config_reg(REG_NUM_CHANNELS, 20'd2);
        write_config_reg(REG_WINDOW_SAMPLES, 20'd3);
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'hFFF);
        drain_averages();
    endtask

    task automatic test_zero_divisor();
        write_config_reg(REG_NUM_CHANNELS, 20'd16);
        write_config_reg(REG_WINDOW_SAMPLES, 20'd5);
        repeat (5) send_sample(SAMPLE_W'($urandom));
        drain_averages();
    endtask

    task automatic test_window_zero();
        write_config_reg(REG_NUM_CHANNELS, 20'd1);
        write_config_reg(REG_WINDOW_SAMPLES, 20'd0);
        send_sample(12'h5A5);
        drain_averages();
    endtask

    // zero acts as one channel, anything above the maximum clamps
    task automatic test_channel_limits();
        write_config_reg(REG_NUM_CHANNELS, 20'd0);
        write_config_reg(REG_WINDOW_SAMPLES, 20'd2);
        send_sample(12'hFFF);
        send_sample(12'h001);
        drain_averages();
        write_config_reg(REG_NUM_CHANNELS, 20'hFFFFF);
        write_config_reg(REG_WINDOW_SAMPLES, 20'd1);
        send_sample(12'hA5A);
        drain_averages();
    endtask

    task automatic test_window_shortened();
        write_config_reg(REG_NUM_CHANNELS, 20'd1);
        write_config_reg(REG_WINDOW_SAMPLES, 20'd1000000);
        send_sample(12'h800);
        send_sample(12'h7FF);
        drain_averages();
        write_config_reg(REG_WINDOW_SAMPLES, 20'hFFFFF);
        send_sample(12'h123);
        drain_averages();
        write_config_reg(REG_WINDOW_SAMPLES, 20'd2);
        send_sample(12'hEDC);
        drain_averages();
    endtask

    // channel count lowered mid-window, position must wrap
    task automatic test_position_wrap();
        write_config_reg(REG_NUM_CHANNELS, 20'd3);
        write_config_reg(REG_WINDOW_SAMPLES, 20'd6);
        send_sample(12'h111);
        send_sample(12'h222);
        drain_averages();
        write_config_reg(REG_NUM_CHANNELS, 20'd2);
        repeat (4) send_sample(SAMPLE_W'($urandom));
        drain_averages();
    endtask

    task automatic test_backpressure();
        int saved_send;
        int saved_recv;
        saved_send = send_idle_pct;
        saved_recv = recv_stall_pct;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_config_reg(REG_NUM_CHANNELS, 20'd4);
        write_config_reg(REG_WINDOW_SAMPLES, 20'd4);
        hold_off_request = 1'b1;
        repeat (24) send_sample(SAMPLE_W'($urandom));
        drain_averages();
        send_idle_pct = saved_send;
        recv_stall_pct = saved_recv;
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
        int sent;
        int n;
        int win;
        int burst;
        logic [CC_W-1:0]     cc;
        logic [SAMPLE_W-1:0] value;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < count)
        begin
            drain_averages();
            case ($urandom_range(9))
                0:       cc = '0;
                1:       cc = CC_W'($urandom_range(31, 17));
                2:       cc = CC_W'(MAX_CH);
                default: cc = CC_W'($urandom_range(MAX_CH, 1));
            endcase
            write_config_reg(REG_NUM_CHANNELS, {15'($urandom), cc});
            n = (cc == 0) ? 1 : ((cc > MAX_CH) ? MAX_CH : cc);
            case ($urandom_range(7))
                0:       win = $urandom_range(n - 1);
                1:       win = $urandom_range(60, 1);
                default: win = n * $urandom_range(3, 1);
            endcase
            write_config_reg(REG_WINDOW_SAMPLES, WS_W'(win));
            burst = (win == 0) ? $urandom_range(3, 1) : win;
            if ($urandom_range(4) == 0)
                burst = $urandom_range(burst);
            repeat (burst)
            begin
                case ($urandom_range(7))
                    0, 1:    value = AVG_MAX;
                    2:       value = '0;
                    default: value = SAMPLE_W'($urandom);
                endcase
                send_sample(value);
                sent++;
            end
        end
        drain_averages();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_channels();
        test_saturation();
        test_zero_divisor();
        test_window_zero();
        test_channel_limits();
        test_window_shortened();
        test_position_wrap();
        test_backpressure();

        run_random_phase(17, 56, 30);
        run_random_phase(56, 17, 30);
        run_random_phase(0, 0, 30);

        drain_averages();
        if (avg_queue.size() != 0)
        begin
            $error("%0d expected averages never arrived", avg_queue.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
